### src/positional_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, codes and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // compare width for position against count
  localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int DATA_W   = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic              seek_pos;
    logic              seek_val;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  where;
  } probe_t;

endpackage

### src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words with insert, delete, get, locate and clear.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------
//  in      | in  | in_valid_i/in_stall_o | operation_i, position_i, value_i
//  out     | out | out_valid_o/out_stall_i | status_o, value_out_o,
//          |     |                       | found_position_o, length_out_o, is_empty_o
//
//  Insert, clear, unused codes and rejected positions go from the request
//  straight to the finish state. Get, delete and locate first pass through
//  the sweep state while the probe walks the cell chain one cell per cycle.
//  One request in flight; in_stall_o is low only while the sequencer idles.
//  The result register lets a new request enter while the previous result
//  is still stalled; a finished request waits in place until that slot frees.
//  Reset clears the length and control; entries are not cleared.
//
// Structure: a row of CAPACITY cells, one list slot each. Insert and delete
// shift every slot at or past the position by one neighbor, all at once.
// Reads and searches send a token from cell 0 to the last cell; each cell
// fills it on the first hit and passes it along.
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_out_o,
  output logic [7:0]  found_position_o,
  output logic [7:0]  length_out_o,
  output logic        is_empty_o
);

  localparam int N = ple_pkg::CAPACITY;

  ple_pkg::cmd_t              cmd;
  ple_pkg::probe_t            probe_w [N+1];
  logic [ple_pkg::DATA_W-1:0] entry_w [N];
  logic [ple_pkg::DATA_W-1:0] left_w  [N];
  logic [ple_pkg::DATA_W-1:0] right_w [N];

  // token enters empty at the head of the chain
  assign probe_w[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = '0;
    end else begin : g_body
      assign left_w[i] = entry_w[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = entry_w[i+1];
    end

    ple_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .my_idx_i      (ple_pkg::IDX_W'(i)),
      .left_entry_i  (left_w[i]),
      .right_entry_i (right_w[i]),
      .probe_i       (probe_w[i]),
      .entry_o       (entry_w[i]),
      .probe_o       (probe_w[i+1])
    );
  end

  ple_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .found_position_o (found_position_o),
    .length_out_o     (length_out_o),
    .is_empty_o       (is_empty_o),
    .probe_last_i     (probe_w[N]),
    .cmd_o            (cmd)
  );

  // a taken request blocks the port on the following cycle
  `PLE_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o,
                   "request port open right after a request")
  // length never passes capacity
  `PLE_ASSERT_NOW(a_len_bound, out_valid_o, 32'(length_out_o) <= 32'(N),
                  "length beyond capacity")
  // a found position only comes with ok status
  `PLE_ASSERT_NOW(a_found_ok, out_valid_o && (found_position_o != 8'd0),
                  status_o == 2'(ple_pkg::ST_OK), "found position with bad status")
  // shift up and shift down never happen together
  `PLE_ASSERT_NOW(a_one_shift, cmd.ins_en, !cmd.del_en, "insert and delete shift at once")

endmodule

### src/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors, passes the probe.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ple_pkg::cmd_t               cmd_i,
  input  logic [ple_pkg::IDX_W-1:0]   my_idx_i,
  input  logic [ple_pkg::DATA_W-1:0]  left_entry_i,
  input  logic [ple_pkg::DATA_W-1:0]  right_entry_i,
  input  ple_pkg::probe_t             probe_i,
  output logic [ple_pkg::DATA_W-1:0]  entry_o,
  output ple_pkg::probe_t             probe_o
);

  logic [ple_pkg::DATA_W-1:0] entry_q, entry_d;
  ple_pkg::probe_t            probe_q, probe_d;
  logic                       here, above, in_list, match;

  assign here    = (my_idx_i == cmd_i.idx);
  assign above   = (my_idx_i > cmd_i.idx);
  assign in_list = (ple_pkg::CNT_W'(my_idx_i) < cmd_i.count);
  assign match   = (cmd_i.seek_pos && here) ||
                   (cmd_i.seek_val && in_list && (entry_q == cmd_i.value));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en) begin
      if (above) begin
        entry_d = left_entry_i;
      end else if (here) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del_en && (above || here)) begin
      entry_d = right_entry_i;
    end
  end

  // first hit along the chain wins
  always_comb begin
    probe_d = probe_i;
    if (!probe_i.hit && match) begin
      probe_d.hit   = 1'b1;
      probe_d.data  = entry_q;
      probe_d.where = my_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;

endmodule

### src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: checks positions, times the probe sweep, commits shifts
// and length, and holds the result register.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  operation_i,
  input  logic [7:0]                  position_i,
  input  logic [31:0]                 value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [31:0]                 value_out_o,
  output logic [7:0]                  found_position_o,
  output logic [7:0]                  length_out_o,
  output logic                        is_empty_o,
  input  ple_pkg::probe_t             probe_last_i,
  output ple_pkg::cmd_t               cmd_o
);

  localparam int CW = ple_pkg::CMP_W;

  ple_pkg::state_e            state_q, state_d;
  logic [2:0]                 op_q;
  logic [ple_pkg::IDX_W-1:0]  idx_q;
  logic [31:0]                value_q;
  ple_pkg::status_e           status_q, status_acc;
  logic [ple_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ple_pkg::IDX_W-1:0]  sweep_q;
  logic                       need_sweep;

  logic                       out_valid_q;
  logic [1:0]                 status_out_q;
  logic [31:0]                value_out_q;
  logic [7:0]                 found_q;
  logic [7:0]                 length_q;
  logic                       empty_q;

  logic                       accept, slot_free, commit, op_ok, sweep_last;
  logic                       pos_zero, ins_bad, rd_bad, full;
  logic [CW-1:0]              pos_w, cnt_w;

  assign pos_w    = CW'(position_i);
  assign cnt_w    = CW'(count_q);
  assign pos_zero = (position_i == 8'd0);
  assign ins_bad  = pos_zero || (pos_w > (cnt_w + CW'(1)));
  assign rd_bad   = pos_zero || (pos_w > cnt_w);
  assign full     = (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY));

  always_comb begin
    status_acc = ple_pkg::ST_OK;
    need_sweep = 1'b0;
    unique case (operation_i)
      ple_pkg::OP_INSERT: begin
        if (ins_bad) begin
          status_acc = ple_pkg::ST_BADPOS;
        end else if (full) begin
          status_acc = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::OP_DELETE, ple_pkg::OP_GET: begin
        if (rd_bad) begin
          status_acc = ple_pkg::ST_BADPOS;
        end else begin
          need_sweep = 1'b1;
        end
      end
      ple_pkg::OP_LOCATE: begin
        status_acc = ple_pkg::ST_NOTFOUND;
        need_sweep = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign sweep_last = (sweep_q == ple_pkg::IDX_W'(ple_pkg::CAPACITY - 1));
  assign op_ok      = (status_q == ple_pkg::ST_OK);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = need_sweep ? ple_pkg::S_SWEEP : ple_pkg::S_FINISH;
        end
      end
      ple_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_d = ple_pkg::S_FINISH;
        end
      end
      ple_pkg::S_FINISH: begin
        if (slot_free) begin
          state_d = ple_pkg::S_IDLE;
        end
      end
      default: state_d = ple_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    accept     = 1'b0;
    commit     = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ple_pkg::S_SWEEP: begin
      end
      ple_pkg::S_FINISH: begin
        commit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (commit && op_ok) begin
      unique case (op_q)
        ple_pkg::OP_INSERT: count_d = count_q + ple_pkg::CNT_W'(1);
        ple_pkg::OP_DELETE: count_d = count_q - ple_pkg::CNT_W'(1);
        ple_pkg::OP_CLEAR:  count_d = '0;
        default:            count_d = count_q;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.ins_en   = commit && op_ok && (op_q == ple_pkg::OP_INSERT);
    cmd_o.del_en   = commit && op_ok && (op_q == ple_pkg::OP_DELETE);
    cmd_o.seek_pos = (op_q == ple_pkg::OP_DELETE) || (op_q == ple_pkg::OP_GET);
    cmd_o.seek_val = (op_q == ple_pkg::OP_LOCATE);
    cmd_o.idx      = idx_q;
    cmd_o.value    = value_q;
    cmd_o.count    = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) begin
        sweep_q <= '0;
      end else if (state_q == ple_pkg::S_SWEEP) begin
        sweep_q <= sweep_q + ple_pkg::IDX_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      idx_q    <= ple_pkg::IDX_W'(pos_w - CW'(1));
      value_q  <= value_i;
      status_q <= status_acc;
    end
    if (commit) begin
      status_out_q <= status_q;
      value_out_q  <= '0;
      found_q      <= '0;
      if (op_q == ple_pkg::OP_LOCATE) begin
        status_out_q <= probe_last_i.hit ? ple_pkg::ST_OK : ple_pkg::ST_NOTFOUND;
        if (probe_last_i.hit) begin
          found_q <= 8'(CW'(probe_last_i.where) + CW'(1));
        end
      end
      if (op_ok && ((op_q == ple_pkg::OP_GET) || (op_q == ple_pkg::OP_DELETE))) begin
        value_out_q <= probe_last_i.data;
      end
      length_q <= 8'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_out_q;
  assign value_out_o      = value_out_q;
  assign found_position_o = found_q;
  assign length_out_o     = length_q;
  assign is_empty_o       = empty_q;

endmodule
